### rtl/core/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is applied
`define BMS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is applied
`define BMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/core/bms_fd_pkg.sv
// types and constants of the battery management frame deframer
`default_nettype none

package bms_fd_pkg;

	localparam int BYTE_W = 8;
	localparam int IDX_W  = 6;
	localparam int LEN_W  = 7;
	localparam int SUM_W  = 16;

	localparam logic [BYTE_W-1:0] BYTE_START = 8'hDD;
	localparam logic [BYTE_W-1:0] BYTE_STOP  = 8'h77;

	typedef enum logic [3:0] {
		PH_HUNT,
		PH_CMD,
		PH_STATUS,
		PH_LEN,
		PH_DATA,
		PH_CHK_HI,
		PH_CHK_LO,
		PH_STOP,
		PH_EMIT
	} phase_t;

endpackage

`default_nettype wire

### rtl/core/bms_fd_if.sv
// valid/ready channels for received bytes and deframed payload items
`default_nettype none

interface bms_fd_rx_if;
	logic                           valid;
	logic                           ready;
	logic [bms_fd_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bms_fd_tx_if;
	logic                           valid;
	logic                           ready;
	logic [bms_fd_pkg::BYTE_W-1:0]  payload_byte;
	logic [bms_fd_pkg::IDX_W-1:0]   payload_index;
	logic                           has_payload;
	logic [bms_fd_pkg::BYTE_W-1:0]  frame_command;
	logic [bms_fd_pkg::BYTE_W-1:0]  frame_status;
	logic [bms_fd_pkg::LEN_W-1:0]   frame_length;
	logic                           last_of_frame;

	modport source (
		output valid, output payload_byte, output payload_index, output has_payload,
		output frame_command, output frame_status, output frame_length,
		output last_of_frame, input ready
	);
	modport sink (
		input valid, input payload_byte, input payload_index, input has_payload,
		input frame_command, input frame_status, input frame_length,
		input last_of_frame, output ready
	);
endinterface

`default_nettype wire

### rtl/core/bms_frame_deframer_top.sv
// battery management uart frame deframer with payload buffer memory
// rx_ch takes one received uart byte per item, one item per cycle while parsing.
// frames are 0xDD, command, status, length, data bytes, checksum high/low, 0x77.
// the checksum is the 16-bit negated sum of status, length and data bytes.
// data bytes are written into a one-port-write, one-port-read buffer memory.
// on a good stop byte the block enters a readout phase: rx_ch.ready drops and
// the buffer is read one entry per cycle while tx_ch is not stalled, straight
// into the tx_ch output register. the first result follows the stop byte through
// the phase register and the output register; a frame of n data bytes gives n
// items at one per cycle unless tx_ch stalls, an empty frame gives one item with
// has_payload low. rx_ch.ready returns in the cycle after the last read is issued,
// so the next frame is taken while the final item still waits on tx_ch. a stall
// on tx_ch holds the output register and pauses the buffer read. a frame of n
// data bytes is n + 7 bytes; the single memory read port sets the readout rate.
// bad length, checksum or stop byte drops the frame without any item.
// reset returns the parser to hunting for a start byte and empties tx_ch;
// the buffer needs no clearing since every entry is written before it is read.
`default_nettype none

module bms_frame_deframer_top #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	bms_fd_rx_if.sink          rx_ch,
	bms_fd_tx_if.source        tx_ch
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [bms_fd_pkg::BYTE_W-1:0] MAX_LEN = bms_fd_pkg::BYTE_W'(MAX_PAYLOAD);

	bms_fd_pkg::phase_t phase_q, phase_d;

	logic [bms_fd_pkg::BYTE_W-1:0] held_cmd_q;
	logic [bms_fd_pkg::BYTE_W-1:0] held_status_q;
	logic [bms_fd_pkg::LEN_W-1:0]  held_len_q;
	logic [bms_fd_pkg::BYTE_W-1:0] chk_hi_q;
	logic [bms_fd_pkg::LEN_W-1:0]  fill_q;
	logic [bms_fd_pkg::SUM_W-1:0]  sum_q;
	logic [bms_fd_pkg::LEN_W-1:0]  rd_ptr_q;

	logic [bms_fd_pkg::BYTE_W-1:0] buf_mem [MAX_PAYLOAD];
	logic [bms_fd_pkg::BYTE_W-1:0] rd_data_q;

	logic                          tx_valid_q;
	logic [bms_fd_pkg::IDX_W-1:0]  out_idx_q;
	logic                          out_has_q;
	logic                          out_last_q;
	logic [bms_fd_pkg::BYTE_W-1:0] out_cmd_q;
	logic [bms_fd_pkg::BYTE_W-1:0] out_status_q;
	logic [bms_fd_pkg::LEN_W-1:0]  out_len_q;

	logic                          rx_ready;
	logic                          rx_fire;
	logic [bms_fd_pkg::BYTE_W-1:0] b;
	logic                          tx_free;
	logic [bms_fd_pkg::LEN_W-1:0]  fill_inc;
	logic [bms_fd_pkg::SUM_W-1:0]  sum_add;
	logic [bms_fd_pkg::SUM_W-1:0]  chk_sum;
	logic                          chk_ok;
	logic                          rd_last;

	// control strobes from the phase logic
	logic ld_cmd, ld_status, ld_len, clr_fill, wr_en, ld_chk_hi, start_emit;
	logic rd_en, emit_empty;

	assign b        = rx_ch.rx_byte;
	assign rx_ready = (phase_q != bms_fd_pkg::PH_EMIT);
	assign rx_fire  = rx_ch.valid && rx_ready;
	assign tx_free  = !tx_valid_q || tx_ch.ready;
	assign fill_inc = fill_q + bms_fd_pkg::LEN_W'(1);
	assign sum_add  = sum_q + {{(bms_fd_pkg::SUM_W-bms_fd_pkg::BYTE_W){1'b0}}, b};
	// sum plus received checksum wraps to zero when the checksum matches
	assign chk_sum  = sum_q + {chk_hi_q, b};
	assign chk_ok   = (chk_sum == '0);
	assign rd_last  = (rd_ptr_q == held_len_q - bms_fd_pkg::LEN_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bms_fd_pkg::PH_HUNT;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		ld_cmd     = 1'b0;
		ld_status  = 1'b0;
		ld_len     = 1'b0;
		clr_fill   = 1'b0;
		wr_en      = 1'b0;
		ld_chk_hi  = 1'b0;
		start_emit = 1'b0;
		rd_en      = 1'b0;
		emit_empty = 1'b0;
		case (phase_q)
			bms_fd_pkg::PH_HUNT: begin
				if (rx_fire && b == bms_fd_pkg::BYTE_START) begin
					phase_d = bms_fd_pkg::PH_CMD;
				end
			end
			bms_fd_pkg::PH_CMD: begin
				if (rx_fire) begin
					ld_cmd  = 1'b1;
					phase_d = bms_fd_pkg::PH_STATUS;
				end
			end
			bms_fd_pkg::PH_STATUS: begin
				if (rx_fire) begin
					ld_status = 1'b1;
					phase_d   = bms_fd_pkg::PH_LEN;
				end
			end
			bms_fd_pkg::PH_LEN: begin
				if (rx_fire) begin
					clr_fill = 1'b1;
					if (b > MAX_LEN) begin
						phase_d = bms_fd_pkg::PH_HUNT;
					end else begin
						ld_len = 1'b1;
						if (b == '0) begin
							phase_d = bms_fd_pkg::PH_CHK_HI;
						end else begin
							phase_d = bms_fd_pkg::PH_DATA;
						end
					end
				end
			end
			bms_fd_pkg::PH_DATA: begin
				if (rx_fire) begin
					wr_en = 1'b1;
					if (fill_inc >= held_len_q) begin
						phase_d = bms_fd_pkg::PH_CHK_HI;
					end
				end
			end
			bms_fd_pkg::PH_CHK_HI: begin
				if (rx_fire) begin
					ld_chk_hi = 1'b1;
					phase_d   = bms_fd_pkg::PH_CHK_LO;
				end
			end
			bms_fd_pkg::PH_CHK_LO: begin
				if (rx_fire) begin
					phase_d = chk_ok ? bms_fd_pkg::PH_STOP : bms_fd_pkg::PH_HUNT;
				end
			end
			bms_fd_pkg::PH_STOP: begin
				if (rx_fire) begin
					if (b == bms_fd_pkg::BYTE_STOP) begin
						start_emit = 1'b1;
						phase_d    = bms_fd_pkg::PH_EMIT;
					end else begin
						phase_d = bms_fd_pkg::PH_HUNT;
					end
				end
			end
			bms_fd_pkg::PH_EMIT: begin
				// one buffer read, or the empty-frame item, per free output slot
				if (tx_free) begin
					if (held_len_q == '0) begin
						emit_empty = 1'b1;
						phase_d    = bms_fd_pkg::PH_HUNT;
					end else begin
						rd_en = 1'b1;
						if (rd_last) begin
							phase_d = bms_fd_pkg::PH_HUNT;
						end
					end
				end
			end
			default: begin
				phase_d = bms_fd_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			sum_q      <= '0;
			rd_ptr_q   <= '0;
			tx_valid_q <= 1'b0;
		end else begin
			if (clr_fill) begin
				fill_q <= '0;
			end else if (wr_en) begin
				fill_q <= fill_inc;
			end
			if (ld_status) begin
				sum_q <= {{(bms_fd_pkg::SUM_W-bms_fd_pkg::BYTE_W){1'b0}}, b};
			end else if (ld_len || wr_en) begin
				sum_q <= sum_add;
			end
			if (start_emit) begin
				rd_ptr_q <= '0;
			end else if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + bms_fd_pkg::LEN_W'(1);
			end
			if (rd_en || emit_empty) begin
				tx_valid_q <= 1'b1;
			end else if (tx_ch.ready) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_cmd) begin
			held_cmd_q <= b;
		end
		if (ld_status) begin
			held_status_q <= b;
		end
		if (ld_len) begin
			held_len_q <= b[bms_fd_pkg::LEN_W-1:0];
		end
		if (ld_chk_hi) begin
			chk_hi_q <= b;
		end
		// frame fields are copied so the next frame can be parsed under a stall
		if (rd_en || emit_empty) begin
			out_idx_q    <= rd_en ? rd_ptr_q[bms_fd_pkg::IDX_W-1:0] : '0;
			out_has_q    <= rd_en;
			out_last_q   <= emit_empty || rd_last;
			out_cmd_q    <= held_cmd_q;
			out_status_q <= held_status_q;
			out_len_q    <= held_len_q;
		end
	end

	// payload buffer: writes only while parsing, reads only during readout
	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_mem[fill_q[AW-1:0]] <= b;
		end
		if (rd_en) begin
			rd_data_q <= buf_mem[rd_ptr_q[AW-1:0]];
		end
	end

	assign rx_ch.ready          = rx_ready;
	assign tx_ch.valid          = tx_valid_q;
	assign tx_ch.payload_byte   = out_has_q ? rd_data_q : '0;
	assign tx_ch.payload_index  = out_idx_q;
	assign tx_ch.has_payload    = out_has_q;
	assign tx_ch.frame_command  = out_cmd_q;
	assign tx_ch.frame_status   = out_status_q;
	assign tx_ch.frame_length   = out_len_q;
	assign tx_ch.last_of_frame  = out_last_q;

endmodule

`default_nettype wire

### rtl/core/bms_fd_checker.sv
// port-level checks for the frame deframer, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module bms_fd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          tx_valid,
	input wire logic                          tx_ready,
	input wire logic [bms_fd_pkg::BYTE_W-1:0] payload_byte,
	input wire logic [bms_fd_pkg::IDX_W-1:0]  payload_index,
	input wire logic                          has_payload,
	input wire logic [bms_fd_pkg::LEN_W-1:0]  frame_length,
	input wire logic                          last_of_frame
);

	// a stalled item keeps its data byte and position
	`BMS_ASSERT_NEXT(a_stall_hold, clk, arst_n, tx_valid && !tx_ready, tx_valid && $stable(payload_byte) && $stable(payload_index))

	// an empty frame item is a lone, zeroed, final item
	`BMS_ASSERT_IMPLY(a_empty_item, clk, arst_n, tx_valid && !has_payload, last_of_frame && payload_byte == '0 && payload_index == '0 && frame_length == '0)

	// data positions stay inside the frame
	`BMS_ASSERT_IMPLY(a_idx_range, clk, arst_n, tx_valid && has_payload, frame_length != '0 && bms_fd_pkg::LEN_W'(payload_index) < frame_length)

	// the final data item sits at the last position
	`BMS_ASSERT_IMPLY(a_last_pos, clk, arst_n, tx_valid && has_payload && last_of_frame, bms_fd_pkg::LEN_W'(payload_index) == frame_length - bms_fd_pkg::LEN_W'(1))

endmodule

bind bms_frame_deframer_top bms_fd_checker u_bms_fd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.tx_valid      (tx_ch.valid),
	.tx_ready      (tx_ch.ready),
	.payload_byte  (tx_ch.payload_byte),
	.payload_index (tx_ch.payload_index),
	.has_payload   (tx_ch.has_payload),
	.frame_length  (tx_ch.frame_length),
	.last_of_frame (tx_ch.last_of_frame)
);

`default_nettype wire
